### rtl/cswa_pkg.sv
// Shared types, constants, window tables and the cosine table for the window core.
package cswa_pkg;

   // Field and state widths.
   localparam int SAMPLE_WIDTH     = 16;
   localparam int MAX_FRAME        = 1024;
   localparam int POS_BITS         = $clog2(MAX_FRAME);
   localparam int FRAME_LEN_BITS   = 11;
   localparam int PHASE_BITS       = 32;
   localparam int COEF_FRAC_BITS   = 16;
   localparam int ACC_BITS         = 64;
   localparam int Q_BITS           = 30;
   localparam int COEF_SHIFT       = 2 * Q_BITS - COEF_FRAC_BITS;
   localparam int PROD_BITS        = SAMPLE_WIDTH + COEF_FRAC_BITS + 1;

   // Configuration port.
   localparam int CSR_INDEX_BITS   = 4;
   localparam int CSR_DATA_BITS    = FRAME_LEN_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_TYPE  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_LENGTH = CSR_INDEX_BITS'(1);

   // Cosine table geometry: one quarter wave, entries in Q30.
   localparam int COS_DEPTH        = 256;
   localparam int COS_ADDR_BITS    = $clog2(COS_DEPTH);
   localparam int COS_IDX_SHIFT    = Q_BITS - COS_ADDR_BITS;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Sum terms after the constant one, and the term counter width.
   localparam int NUM_TERMS        = 3;
   localparam int TERM_BITS        = $clog2(NUM_TERMS);
   localparam logic [TERM_BITS-1:0] TERM_FIRST  = TERM_BITS'(0);
   localparam logic [TERM_BITS-1:0] TERM_SECOND = TERM_BITS'(1);
   localparam logic [TERM_BITS-1:0] TERM_LAST   = TERM_BITS'(NUM_TERMS - 1);

   // Position limit and phase step after reset, for the longest frame.
   localparam logic [POS_BITS-1:0] LEN_M1_RESET = POS_BITS'(MAX_FRAME - 1);
   localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET = PHASE_BITS'(
      ((longint'(1) << PHASE_BITS) + longint'((MAX_FRAME - 1) / 2)) /
      longint'(MAX_FRAME - 1));
   localparam logic [PHASE_BITS-1:0] QUARTER_TURN = PHASE_BITS'(1) << (PHASE_BITS - 2);

   // Window shapes.
   typedef enum logic [2:0] {
      WIN_RECT,
      WIN_HANN,
      WIN_HAMMING,
      WIN_SINE,
      WIN_BLACKMAN,
      WIN_NUTTALL,
      WIN_BLACKMAN_HARRIS,
      WIN_BLACKMAN_NUTTALL
   } win_kind_type;

   // One word on each data channel.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_re;
      logic signed [SAMPLE_WIDTH-1:0] sample_im;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] windowed_re;
      logic signed [SAMPLE_WIDTH-1:0] windowed_im;
      logic                           last_in_frame;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 load;
      logic                 lookup;
      logic                 mult;
      logic                 accum;
      logic                 coef;
      logic                 prod;
      logic                 out_write;
      logic [TERM_BITS-1:0] term;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic len_write;
      logic div_busy;
      logic out_free;
   } status_type;

   typedef logic [Q_BITS:0] cos_tab_type [COS_DEPTH];

   // Constant term a0 of each window in Q30.
   function automatic logic signed [31:0] win_a0(win_kind_type kind);
      logic signed [31:0] a;
      case (kind)
         WIN_HANN:             a = 32'sd536870912;
         WIN_HAMMING:          a = 32'sd578059648;
         WIN_BLACKMAN:         a = 32'sd450971566;
         WIN_NUTTALL:          a = 32'sd382002981;
         WIN_BLACKMAN_HARRIS:  a = 32'sd385204879;
         WIN_BLACKMAN_NUTTALL: a = 32'sd390393092;
         default:              a = 32'sd0;
      endcase
      return a;
   endfunction

   // Signed weight of each cosine term in Q30, with the alternating sign folded in.
   // The sine window has a single term of weight one on its shifted half phase.
   function automatic logic signed [31:0] win_weight(win_kind_type kind,
                                                     logic [TERM_BITS-1:0] term);
      logic signed [31:0] m1;
      logic signed [31:0] m2;
      logic signed [31:0] m3;
      m1 = 32'sd0;
      m2 = 32'sd0;
      m3 = 32'sd0;
      case (kind)
         WIN_HANN: begin
            m1 = -32'sd536870912;
         end
         WIN_HAMMING: begin
            m1 = -32'sd495682176;
         end
         WIN_SINE: begin
            m1 = 32'sd1073741824;
         end
         WIN_BLACKMAN: begin
            m1 = -32'sd536870912;
            m2 = 32'sd85899346;
         end
         WIN_NUTTALL: begin
            m1 = -32'sd523337470;
            m2 = 32'sd154867931;
            m3 = -32'sd13533442;
         end
         WIN_BLACKMAN_HARRIS: begin
            m1 = -32'sd524297395;
            m2 = 32'sd151698245;
            m3 = -32'sd12541305;
         end
         WIN_BLACKMAN_NUTTALL: begin
            m1 = -32'sd525250341;
            m2 = 32'sd146672596;
            m3 = -32'sd11425794;
         end
         default: begin
            m1 = 32'sd0;
         end
      endcase
      case (term)
         TERM_FIRST:  return m1;
         TERM_SECOND: return m2;
         default:     return m3;
      endcase
   endfunction

   // Unsigned shift-and-subtract long division, used only while building the table.
   function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
      longint unsigned q;
      longint unsigned rem;
      q   = 64'd0;
      rem = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = (rem << 1) | ((num >> b) & 64'd1);
         q   = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q   = q | 64'd1;
         end
      end
      return q;
   endfunction

   // One quarter-wave cosine entry in Q30 from a Taylor series of the constant and nine further terms.
   function automatic logic [Q_BITS:0] cos_entry(int unsigned j);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (HALF_PI_Q30 * longint'(j) + longint'(COS_DEPTH >> 1)) >> COS_ADDR_BITS;
      x2   = (x * x) >> Q_BITS;
      term = longint'(1) << Q_BITS;
      sum  = longint'(1) << Q_BITS;
      for (int k = 1; k <= 9; k++) begin
         term = div_u64((term * x2) >> Q_BITS, longint'((2 * k - 1) * (2 * k)));
         if ((k & 1) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (longint'(1) << Q_BITS)) begin
         sum = longint'(1) << Q_BITS;
      end
      return (Q_BITS + 1)'(sum);
   endfunction

   function automatic cos_tab_type build_cos_tab();
      cos_tab_type t;
      for (int j = 0; j < COS_DEPTH; j++) begin
         t[j] = cos_entry(j);
      end
      return t;
   endfunction

   // Entries 0 .. COS_DEPTH-1, and the quarter-turn entry held on its own.
   localparam cos_tab_type      COS_TAB  = build_cos_tab();
   localparam logic [Q_BITS:0]  COS_LAST = cos_entry(COS_DEPTH);

endpackage

### rtl/cswa_div.sv
// Radix-2 restoring divider that derives the phase step from the frame length.
module cswa_div
   import cswa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [POS_BITS-1:0]   divisor,
   output logic [PHASE_BITS-1:0] quotient,
   output logic                  busy
);

   localparam int CNT_BITS = $clog2(PHASE_BITS + 1);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(PHASE_BITS);

   // Dividend bits shift out of the top while quotient bits shift in at the bottom.
   logic [PHASE_BITS:0]   work_ff;
   logic [PHASE_BITS:0]   work_in;
   logic [POS_BITS-1:0]   rem_ff;
   logic [POS_BITS-1:0]   rem_in;
   logic [POS_BITS-1:0]   den_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  busy_ff;
   logic [POS_BITS:0]     rem_shift;
   logic                  fits;

   // One quotient bit a cycle.
   always_comb begin
      rem_shift = {rem_ff, work_ff[PHASE_BITS]};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_in    = fits ? POS_BITS'(rem_shift - {1'b0, den_ff}) : rem_shift[POS_BITS-1:0];
      work_in   = {work_ff[PHASE_BITS-1:0], fits};
   end

   // The dividend is one full turn plus half the divisor, so the quotient rounds.
   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= {1'b0, PHASE_STEP_RESET};
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         den_ff  <= LEN_M1_RESET;
      end else if (start) begin
         work_ff <= (PHASE_BITS + 1)'(1) << PHASE_BITS | (PHASE_BITS + 1)'(divisor >> 1);
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         den_ff  <= divisor;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // The step wraps modulo one turn, so a frame of two gives zero.
   assign quotient = work_ff[PHASE_BITS-1:0];
   assign busy     = busy_ff;

endmodule

### rtl/cswa_dp.sv
// Datapath: registers, phase accumulator, cosine lookup, coefficient sum and sample scaling.
module cswa_dp
   import cswa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  req_word_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_word_type              rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration and frame state.
   win_kind_type                     wtype_ff;
   logic [POS_BITS-1:0]              len_m1_ff;
   logic [POS_BITS-1:0]              len_m1_in;
   logic [POS_BITS-1:0]              pos_ff;
   logic [PHASE_BITS-1:0]            phase_ff;
   logic [PHASE_BITS-1:0]            step;
   logic                             div_busy;
   logic                             wtype_write;
   logic                             len_write;
   logic                             last_in;

   // Per-word working registers.
   logic signed [SAMPLE_WIDTH-1:0]   re_ff;
   logic signed [SAMPLE_WIDTH-1:0]   im_ff;
   logic                             last_ff;
   logic [PHASE_BITS-1:0]            arg1_ff;
   logic [PHASE_BITS-1:0]            arg2_ff;
   logic [PHASE_BITS-1:0]            arg3_ff;
   logic signed [31:0]               cos_ff;
   logic signed [31:0]               cos_in;
   logic signed [ACC_BITS-1:0]       term_ff;
   logic signed [ACC_BITS-1:0]       acc_ff;
   logic [COEF_FRAC_BITS-1:0]        coef_ff;
   logic [COEF_FRAC_BITS-1:0]        coef_in;
   logic signed [PROD_BITS-1:0]      pre_re_ff;
   logic signed [PROD_BITS-1:0]      pre_im_ff;
   logic                             rsp_valid_ff;
   rsp_word_type                     rsp_word_ff;

   // Lookup signals.
   logic [PHASE_BITS-1:0]            arg;
   logic [1:0]                       quad;
   logic [Q_BITS-1:0]                frac;
   logic [COS_ADDR_BITS:0]           idx;
   logic [COS_ADDR_BITS:0]           addr;
   logic [Q_BITS:0]                  mag;
   logic signed [ACC_BITS-1:0]       rounded;

   // Round half up by the coefficient's fraction bits and clamp to the sample range.
   function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
      logic signed [PROD_BITS-1:0] p);
      logic signed [PROD_BITS-1:0]             s;
      logic signed [PROD_BITS-COEF_FRAC_BITS-1:0] y;
      s = p + (PROD_BITS'(1) << (COEF_FRAC_BITS - 1));
      y = s[PROD_BITS-1:COEF_FRAC_BITS];
      if (y > (PROD_BITS - COEF_FRAC_BITS)'(2 ** (SAMPLE_WIDTH - 1) - 1)) begin
         return {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
      end else if (y < -(PROD_BITS - COEF_FRAC_BITS)'(2 ** (SAMPLE_WIDTH - 1))) begin
         return {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
      end
      return y[SAMPLE_WIDTH-1:0];
   endfunction

   // Register write decode, frame length clamped to the supported range.
   always_comb begin
      wtype_write = csr_write_en && (csr_index == CSR_WINDOW_TYPE);
      len_write   = csr_write_en && (csr_index == CSR_FRAME_LENGTH);
      if (csr_wdata < CSR_DATA_BITS'(2)) begin
         len_m1_in = POS_BITS'(1);
      end else if (csr_wdata > CSR_DATA_BITS'(MAX_FRAME)) begin
         len_m1_in = POS_BITS'(MAX_FRAME - 1);
      end else begin
         len_m1_in = POS_BITS'(csr_wdata - CSR_DATA_BITS'(1));
      end
      last_in = pos_ff >= len_m1_ff;
   end

   cswa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (len_write),
      .divisor  (len_m1_in),
      .quotient (step),
      .busy     (div_busy)
   );

   // Quarter-wave lookup: quadrant from the top bits, nearest entry, no interpolation.
   always_comb begin
      case (cmd.term)
         TERM_FIRST:  arg = arg1_ff;
         TERM_SECOND: arg = arg2_ff;
         default:     arg = arg3_ff;
      endcase
      quad = arg[PHASE_BITS-1:PHASE_BITS-2];
      frac = arg[Q_BITS-1:0];
      idx  = {1'b0, frac[Q_BITS-1 -: COS_ADDR_BITS]}
           + (COS_ADDR_BITS + 1)'(frac[COS_IDX_SHIFT-1]);
      addr = quad[0] ? (COS_ADDR_BITS + 1)'(COS_DEPTH) - idx : idx;
      mag  = addr[COS_ADDR_BITS] ? COS_LAST : COS_TAB[addr[COS_ADDR_BITS-1:0]];
      if (quad[0] ^ quad[1]) begin
         cos_in = -$signed({1'b0, mag});
      end else begin
         cos_in = $signed({1'b0, mag});
      end
   end

   // Coefficient: zero for a sum at or below zero, else rounded and clamped.
   always_comb begin
      rounded = acc_ff + (ACC_BITS'(1) << (COEF_SHIFT - 1));
      if (acc_ff <= 0) begin
         coef_in = '0;
      end else if (rounded[ACC_BITS-2:COEF_SHIFT] >
                   (ACC_BITS - 1 - COEF_SHIFT)'(2 ** COEF_FRAC_BITS - 1)) begin
         coef_in = '1;
      end else begin
         coef_in = rounded[COEF_SHIFT+COEF_FRAC_BITS-1:COEF_SHIFT];
      end
   end

   // Control state: configuration, frame position, phase and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         wtype_ff     <= WIN_RECT;
         len_m1_ff    <= LEN_M1_RESET;
         pos_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wtype_write) begin
            wtype_ff <= win_kind_type'(csr_wdata[2:0]);
         end
         if (len_write) begin
            len_m1_ff <= len_m1_in;
            pos_ff    <= '0;
            phase_ff  <= '0;
         end else if (cmd.load) begin
            if (last_in) begin
               pos_ff   <= '0;
               phase_ff <= '0;
            end else begin
               pos_ff   <= pos_ff + POS_BITS'(1);
               phase_ff <= phase_ff + step;
            end
         end
         if (cmd.out_write) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers for the word in flight.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         re_ff   <= req_data.sample_re;
         im_ff   <= req_data.sample_im;
         last_ff <= last_in;
         if (wtype_ff == WIN_SINE) begin
            arg1_ff <= (phase_ff >> 1) - QUARTER_TURN;
         end else begin
            arg1_ff <= phase_ff;
         end
         arg2_ff <= phase_ff << 1;
         arg3_ff <= phase_ff + (phase_ff << 1);
         acc_ff  <= ACC_BITS'(win_a0(wtype_ff)) <<< Q_BITS;
      end
      if (cmd.lookup) begin
         cos_ff <= cos_in;
      end
      if (cmd.mult) begin
         term_ff <= win_weight(wtype_ff, cmd.term) * cos_ff;
      end
      if (cmd.accum) begin
         acc_ff <= acc_ff + term_ff;
      end
      if (cmd.coef) begin
         coef_ff <= coef_in;
      end
      if (cmd.prod) begin
         pre_re_ff <= re_ff * $signed({1'b0, coef_ff});
         pre_im_ff <= im_ff * $signed({1'b0, coef_ff});
      end
      if (cmd.out_write) begin
         rsp_word_ff.last_in_frame <= last_ff;
         if (wtype_ff == WIN_RECT) begin
            rsp_word_ff.windowed_re <= re_ff;
            rsp_word_ff.windowed_im <= im_ff;
         end else begin
            rsp_word_ff.windowed_re <= round_sat(pre_re_ff);
            rsp_word_ff.windowed_im <= round_sat(pre_im_ff);
         end
      end
   end

   assign status.len_write = len_write;
   assign status.div_busy  = div_busy;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_word_ff;

endmodule

### rtl/cswa_ctrl.sv
// Controller: sequences accept, the three cosine terms, coefficient, scaling and output write.
module cswa_ctrl
   import cswa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_MULT,
      ST_ACCUM,
      ST_COEF,
      ST_PROD,
      ST_OUT
   } state_type;

   state_type            state_ff;
   logic [TERM_BITS-1:0] term_ff;
   logic                 accept;

   // A word is taken only when no step recompute or frame length write is pending.
   assign req_ready = (state_ff == ST_IDLE) && !status.len_write && !status.div_busy;
   assign accept    = req_valid && req_ready;

   // State and term counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_LOOKUP;
                  term_ff  <= TERM_FIRST;
               end
            end
            ST_LOOKUP: begin
               state_ff <= ST_MULT;
            end
            ST_MULT: begin
               state_ff <= ST_ACCUM;
            end
            ST_ACCUM: begin
               if (term_ff == TERM_LAST) begin
                  state_ff <= ST_COEF;
               end else begin
                  term_ff  <= term_ff + TERM_BITS'(1);
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_COEF: begin
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Datapath commands decoded from the state.
   always_comb begin
      cmd           = '0;
      cmd.term      = term_ff;
      cmd.load      = accept;
      cmd.lookup    = state_ff == ST_LOOKUP;
      cmd.mult      = state_ff == ST_MULT;
      cmd.accum     = state_ff == ST_ACCUM;
      cmd.coef      = state_ff == ST_COEF;
      cmd.prod      = state_ff == ST_PROD;
      cmd.out_write = (state_ff == ST_OUT) && status.out_free;
   end

endmodule

### rtl/cosine_sum_window_apply_core.sv
// Top level of the cosine-sum window core: controller and datapath.
//
// Multiplies each complex sample word by the window coefficient for its position in the
// frame (rectangular, Hann, Hamming, sine, Blackman, Nuttall, Blackman-Harris or
// Blackman-Nuttall), rounding half up and saturating, and flags the last word of each
// frame. One word is in work at a time, from acceptance to the output register: the three
// cosine terms go one after another through a shared lookup, a 32x32 multiplier and a
// 64-bit accumulator, followed by the coefficient, the sample products and the output
// write, which waits while the output side is stalled. A new word is accepted only once
// the last has been written to the output register. The output register lets a finished
// word wait while the next is already accepted. Writing frame_length restarts the frame
// and recomputes the phase step in a bit-serial divider; until the divider is done,
// req_ready stays low while csr writes are still taken. The window type may be changed
// between words; it applies from the next word.
module cosine_sum_window_apply_core
   import cswa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_word_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_word_type              rsp_data,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   cswa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cswa_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule
